[sv/agcng_pkg.sv]
// Shared types, constants, gain and level tables for the audio AGC with noise gate.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package agcng_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 8;
    localparam int ABS_W      = SAMPLE_W - 1;
    localparam int MEAN_SHIFT = 8;
    localparam int SUM_W      = ABS_W + MEAN_SHIFT;
    localparam int MCOUNT_W   = MEAN_SHIFT + 1;
    localparam int GAIN_STEP  = 4;
    localparam int FRAME_W    = 16;
    localparam int SEL_W      = 3;
    localparam int EXP_W      = 3;
    localparam int COUNT_W    = 8;
    localparam int FRAC_SHIFT = 11;
    localparam int THR_SHIFT  = 4;
    localparam int PROD_W     = SAMPLE_W + SAMPLE_W + 1;
    localparam int SHAMT_W    = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]   MUTE_CODE         = 8'hFF;
    localparam logic [GAIN_W-1:0]   GAIN_MAX_CODE     = 8'hFF;
    localparam logic [GAIN_W-1:0]   RST_GAIN_FLOOR    = 8'd64;
    localparam logic [GAIN_W-1:0]   RST_DEFAULT_GAIN  = 8'd64;
    localparam logic [FRAME_W-1:0]  RST_FRAME_LENGTH  = 16'd480;
    localparam logic [MCOUNT_W-1:0] MEAN_RELOAD       = MCOUNT_W'(1) << MEAN_SHIFT;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SELECT  = 3'd0,
        CFG_GATE_SELECT    = 3'd1,
        CFG_GATE_ENABLE    = 3'd2,
        CFG_GAIN_FLOOR     = 3'd3,
        CFG_DEFAULT_GAIN   = 3'd4,
        CFG_FRAME_LENGTH   = 3'd5,
        CFG_ATTACK_EXP     = 3'd6,
        CFG_DECAY_EXP      = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        LOOP_HOLD     = 2'd0,
        LOOP_COMPRESS = 2'd1,
        LOOP_EXPAND   = 2'd2
    } t_loop_mode;

    // Q15 fraction per low nibble of the gain code (0.375 dB steps)
    localparam logic [15:0] FRAC_TAB [16] = '{
        16'd32768, 16'd31383, 16'd30057, 16'd28787,
        16'd27571, 16'd26406, 16'd25290, 16'd24221,
        16'd23198, 16'd22218, 16'd21279, 16'd20380,
        16'd19519, 16'd18694, 16'd17904, 16'd17147
    };

    // Target peak, -3 dB to -24 dB
    localparam logic [ABS_W-1:0] TARGET_TAB [8] = '{
        15'd23198, 15'd16423, 15'd11627, 15'd8231,
        15'd5827,  15'd4125,  15'd2920,  15'd2068
    };

    // Noise gate level, -30 dB to -72 dB
    localparam logic [ABS_W-1:0] GATE_TAB [8] = '{
        15'd1036, 15'd519, 15'd260, 15'd131,
        15'd65,   15'd33,  15'd16,  15'd8
    };

    // Magnitude with the most negative value clipped to full scale
    function automatic logic [ABS_W-1:0] sat_abs(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] neg;
        neg = -v;
        if (v == SAMPLE_MIN) begin
            sat_abs = ABS_W'(SAMPLE_MAX);
        end else if (v[SAMPLE_W-1]) begin
            sat_abs = neg[ABS_W-1:0];
        end else begin
            sat_abs = v[ABS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[sv/agcng_in_if.sv]
// Input stream channel: valid/ready handshake carrying one PCM sample word.
// Depends on agcng_pkg for the sample width.
`default_nettype none

interface agcng_in_if
    import agcng_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

[sv/agcng_out_if.sv]
// Output stream channel: valid/ready handshake carrying gained sample, gain code, gate flag.
// Depends on agcng_pkg for field widths.
`default_nettype none

interface agcng_out_if
    import agcng_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [GAIN_W-1:0]          applied_gain;
    logic                       gated;

    modport source (output valid, output sample_out, output applied_gain, output gated,
                    input ready);
    modport sink   (input valid, input sample_out, input applied_gain, input gated,
                    output ready);
endinterface

`default_nettype wire

[sv/audio_agc_with_noise_gate_core.sv]
// Top level of the audio AGC with noise gate: handshake, state, gain loop, config.
// Depends on agcng_pkg, agcng_in_if, agcng_out_if and agcng_gain_apply.
`default_nettype none

// Automatic gain control for signed 16-bit PCM with a noise gate. Each sample word
// is scaled by an 8-bit attenuation code (0.375 dB steps, code 64 is unity, code 0
// is +24 dB, code 255 mutes). A new gain code takes effect only at a strict sign
// change of the input, so gain steps land near zero crossings. The mean |input|
// over blocks of 256 samples sets a noise flag; with gate_enable set, that flag
// mutes the output and raises the gated bit. The peak |output| of each frame of
// frame_length samples raises the attenuation by 4 when above the target level,
// or lowers it by 4 when above the gate threshold, at most once per 2^attack or
// 2^decay frames; each frame-end update keeps the code at or above the gain floor.
// Throughput is one word per clock while the output is not stalled: the sample is
// captured in an input register, and one combinational pass (noise detector, one
// 16x17 multiply with shift and saturation, peak and gain-loop update) writes the
// result register and all loop state as the word leaves the input register.
// Back-pressure on the output stalls the input register; the result register holds
// until taken. Write configuration only while no word is in flight. Writing
// target_select, gate_select or gate_enable restarts the noise detector and puts
// the loop in hold; writing default_gain_code loads the running gain; writing
// frame_length restarts the frame.

module audio_agc_with_noise_gate_core
    import agcng_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    agcng_in_if.sink                   i_in,
    agcng_out_if.source                o_out
);

    // configuration registers
    logic [SEL_W-1:0]   r_target_select;
    logic [SEL_W-1:0]   r_gate_select;
    logic               r_gate_enable;
    logic [GAIN_W-1:0]  r_gain_floor;
    logic [FRAME_W-1:0] r_frame_length;
    logic [EXP_W-1:0]   r_attack_exp;
    logic [EXP_W-1:0]   r_decay_exp;

    // handshake and payload registers
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_in_sample;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [GAIN_W-1:0]          r_out_gain;
    logic                       r_out_gated;

    // loop state and next values
    logic [SUM_W-1:0]    r_abs_sum,     n_abs_sum;
    logic [MCOUNT_W-1:0] r_mean_count,  n_mean_count;
    logic                r_quiet,       n_quiet;
    logic [ABS_W-1:0]    r_peak,        n_peak;
    logic [FRAME_W-1:0]  r_frame_count, n_frame_count;
    t_loop_mode          r_loop_mode,   n_loop_mode;
    logic [COUNT_W-1:0]  r_attack_cnt,  n_attack_cnt;
    logic [COUNT_W-1:0]  r_decay_cnt,   n_decay_cnt;
    logic [GAIN_W-1:0]   r_current_gain, n_current_gain;
    logic [GAIN_W-1:0]   r_buffered_gain, n_buffered_gain;
    // sign of the previous input word is all the zero-cross test needs
    logic                r_prev_neg,    n_prev_neg;
    logic                r_prev_pos,    n_prev_pos;

    // datapath intermediates
    logic                       accept;
    logic                       advance;
    logic [ABS_W-1:0]           abs_x;
    logic [SUM_W-1:0]           sum_next;
    logic [ABS_W-1:0]           block_mean;
    logic                       block_end;
    logic                       noise_now;
    logic                       x_neg;
    logic                       x_pos;
    logic                       zero_cross;
    logic [GAIN_W-1:0]          apply_gain;
    logic                       gated;
    logic signed [SAMPLE_W-1:0] y;
    logic [ABS_W-1:0]           abs_y;
    logic [ABS_W-1:0]           peak_now;
    logic [3:0]                 hi_nib;
    logic [ABS_W-1:0]           gate_level;
    logic [ABS_W-1:0]           threshold;
    logic [GAIN_W:0]            gain_up;
    logic [GAIN_W-1:0]          gain_step;
    logic [GAIN_W-1:0]          gain_down;
    logic [COUNT_W-1:0]         attack_dec;
    logic [COUNT_W-1:0]         decay_dec;

    // handshake: the input register refills whenever its word moves on
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign accept      = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_out   = r_out_sample;
    assign o_out.applied_gain = r_out_gain;
    assign o_out.gated        = r_out_gated;

    // noise detector on the input word
    assign abs_x      = sat_abs(r_in_sample);
    assign sum_next   = r_abs_sum + SUM_W'(abs_x);
    assign block_mean = sum_next[SUM_W-1:MEAN_SHIFT];
    assign block_end  = (r_mean_count == MCOUNT_W'(1));
    assign noise_now  = block_end ? (block_mean < GATE_TAB[r_gate_select]) : r_quiet;

    // take the pending gain only at a strict sign change
    assign x_neg      = r_in_sample[SAMPLE_W-1];
    assign x_pos      = !r_in_sample[SAMPLE_W-1] && (r_in_sample != '0);
    assign zero_cross = (r_prev_neg && x_pos) || (r_prev_pos && x_neg);
    assign apply_gain = zero_cross ? r_current_gain : r_buffered_gain;
    assign gated      = r_gate_enable && noise_now;

    agcng_gain_apply u_gain_apply (
        .i_sample (r_in_sample),
        .i_gain   (apply_gain),
        .i_gated  (gated),
        .o_sample (y),
        .o_abs    (abs_y)
    );

    // frame-end decision terms
    assign peak_now   = (abs_y > r_peak) ? abs_y : r_peak;
    assign hi_nib     = r_gain_floor[7:4];
    assign gate_level = GATE_TAB[r_gate_select];
    assign threshold  = (hi_nib <= 4'(THR_SHIFT))
                      ? (gate_level << (4'(THR_SHIFT) - hi_nib))
                      : (gate_level >> (hi_nib - 4'(THR_SHIFT)));
    assign gain_up    = {1'b0, r_current_gain} + (GAIN_W+1)'(GAIN_STEP);
    assign gain_step  = GAIN_W'(GAIN_STEP);
    assign gain_down  = (r_current_gain > gain_step) ? (r_current_gain - gain_step) : '0;
    assign attack_dec = r_attack_cnt - COUNT_W'(1);
    assign decay_dec  = r_decay_cnt - COUNT_W'(1);

    always_comb begin
        n_abs_sum       = r_abs_sum;
        n_mean_count    = r_mean_count;
        n_quiet         = r_quiet;
        n_peak          = r_peak;
        n_frame_count   = r_frame_count;
        n_loop_mode     = r_loop_mode;
        n_attack_cnt    = r_attack_cnt;
        n_decay_cnt     = r_decay_cnt;
        n_current_gain  = r_current_gain;
        n_buffered_gain = r_buffered_gain;
        n_prev_neg      = r_prev_neg;
        n_prev_pos      = r_prev_pos;

        if (advance) begin
            // block mean: close the block or accumulate
            if (block_end) begin
                n_abs_sum    = '0;
                n_mean_count = MEAN_RELOAD;
            end else begin
                n_abs_sum    = sum_next;
                n_mean_count = r_mean_count - MCOUNT_W'(1);
            end
            n_quiet         = noise_now;
            n_buffered_gain = apply_gain;
            n_prev_neg      = x_neg;
            n_prev_pos      = x_pos;

            if (r_frame_count > FRAME_W'(1)) begin
                n_frame_count = r_frame_count - FRAME_W'(1);
                n_peak        = peak_now;
            end else begin
                n_frame_count = r_frame_length;
                n_peak        = '0;
                priority if (peak_now > TARGET_TAB[r_target_select]) begin
                    // attack: step at once on entry, then every 2^attack frames
                    n_loop_mode = LOOP_COMPRESS;
                    if (r_loop_mode == LOOP_COMPRESS) begin
                        n_attack_cnt = attack_dec;
                    end
                    if (r_loop_mode != LOOP_COMPRESS || attack_dec == '0) begin
                        n_current_gain = gain_up[GAIN_W] ? GAIN_MAX_CODE : gain_up[GAIN_W-1:0];
                        n_attack_cnt   = COUNT_W'(1) << r_attack_exp;
                    end
                end else if (peak_now > threshold) begin
                    // decay toward more gain
                    n_loop_mode = LOOP_EXPAND;
                    if (r_loop_mode == LOOP_EXPAND) begin
                        n_decay_cnt = decay_dec;
                    end
                    if (r_loop_mode != LOOP_EXPAND || decay_dec == '0) begin
                        n_current_gain = gain_down;
                        n_decay_cnt    = COUNT_W'(1) << r_decay_exp;
                    end
                end else begin
                    n_loop_mode = r_loop_mode;
                end
                if (n_current_gain < r_gain_floor) begin
                    n_current_gain = r_gain_floor;
                end
            end
        end

        // side effects of configuration writes
        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_SELECT, CFG_GATE_SELECT, CFG_GATE_ENABLE: begin
                    n_abs_sum    = '0;
                    n_mean_count = MEAN_RELOAD;
                    n_quiet      = 1'b0;
                    n_loop_mode  = LOOP_HOLD;
                end
                CFG_DEFAULT_GAIN: begin
                    n_current_gain  = i_cfg_data[GAIN_W-1:0];
                    n_buffered_gain = i_cfg_data[GAIN_W-1:0];
                end
                CFG_FRAME_LENGTH: begin
                    n_frame_count = i_cfg_data[FRAME_W-1:0];
                end
                CFG_GAIN_FLOOR, CFG_ATTACK_EXP, CFG_DECAY_EXP: begin
                end
            endcase
        end
    end

    // configuration registers; the default gain lives only in the running gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_select <= '0;
            r_gate_select   <= '0;
            r_gate_enable   <= 1'b0;
            r_gain_floor    <= RST_GAIN_FLOOR;
            r_frame_length  <= RST_FRAME_LENGTH;
            r_attack_exp    <= '0;
            r_decay_exp     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_SELECT: r_target_select <= i_cfg_data[SEL_W-1:0];
                CFG_GATE_SELECT:   r_gate_select   <= i_cfg_data[SEL_W-1:0];
                CFG_GATE_ENABLE:   r_gate_enable   <= i_cfg_data[0];
                CFG_GAIN_FLOOR:    r_gain_floor    <= i_cfg_data[GAIN_W-1:0];
                CFG_DEFAULT_GAIN: begin
                end
                CFG_FRAME_LENGTH:  r_frame_length  <= i_cfg_data[FRAME_W-1:0];
                CFG_ATTACK_EXP:    r_attack_exp    <= i_cfg_data[EXP_W-1:0];
                CFG_DECAY_EXP:     r_decay_exp     <= i_cfg_data[EXP_W-1:0];
            endcase
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_sum       <= '0;
            r_mean_count    <= MEAN_RELOAD;
            r_quiet         <= 1'b0;
            r_peak          <= '0;
            r_frame_count   <= RST_FRAME_LENGTH;
            r_loop_mode     <= LOOP_HOLD;
            r_attack_cnt    <= '0;
            r_decay_cnt     <= '0;
            r_current_gain  <= RST_DEFAULT_GAIN;
            r_buffered_gain <= RST_DEFAULT_GAIN;
            r_prev_neg      <= 1'b0;
            r_prev_pos      <= 1'b0;
        end else begin
            r_abs_sum       <= n_abs_sum;
            r_mean_count    <= n_mean_count;
            r_quiet         <= n_quiet;
            r_peak          <= n_peak;
            r_frame_count   <= n_frame_count;
            r_loop_mode     <= n_loop_mode;
            r_attack_cnt    <= n_attack_cnt;
            r_decay_cnt     <= n_decay_cnt;
            r_current_gain  <= n_current_gain;
            r_buffered_gain <= n_buffered_gain;
            r_prev_neg      <= n_prev_neg;
            r_prev_pos      <= n_prev_pos;
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sample <= i_in.sample_in;
        end
        if (advance) begin
            r_out_sample <= y;
            r_out_gain   <= apply_gain;
            r_out_gated  <= gated;
        end
    end

endmodule

`default_nettype wire

[sv/agcng_gain_apply.sv]
// Gain datapath: Q15 fraction multiply, code-dependent floor shift, 16-bit saturation.
// Depends on agcng_pkg for tables, widths and sat_abs.
`default_nettype none

module agcng_gain_apply
    import agcng_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [GAIN_W-1:0]          i_gain,
    input  wire logic                       i_gated,
    output logic signed [SAMPLE_W-1:0]      o_sample,
    output logic [ABS_W-1:0]                o_abs
);

    logic signed [SAMPLE_W:0]   frac_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   shifted;
    logic [SHAMT_W-1:0]         shamt;
    logic                       mute;

    assign frac_s  = {1'b0, FRAC_TAB[i_gain[3:0]]};
    assign prod    = i_sample * frac_s;
    assign shamt   = SHAMT_W'(FRAC_SHIFT) + {1'b0, i_gain[7:4]};
    // arithmetic shift floors toward minus infinity
    assign shifted = prod >>> shamt;
    assign mute    = i_gated || (i_gain == MUTE_CODE);

    always_comb begin
        if (mute) begin
            o_sample = '0;
        end else if (shifted > PROD_W'(SAMPLE_MAX)) begin
            o_sample = SAMPLE_MAX;
        end else if (shifted < PROD_W'(SAMPLE_MIN)) begin
            o_sample = SAMPLE_MIN;
        end else begin
            o_sample = shifted[SAMPLE_W-1:0];
        end
    end

    assign o_abs = sat_abs(o_sample);

endmodule

`default_nettype wire

[sim/audio_agc_with_noise_gate_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for audio_agc_with_noise_gate_core: PCM words in, gained words out.
// Depends on agcng_pkg, agcng_in_if, agcng_out_if and the core itself.

module audio_agc_with_noise_gate_core_tb
    import agcng_pkg::*;
;

    // ------------------------------------------------------------------
    // Bench constants and the bench's own copy of the level tables
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS   = 285;
    localparam int MEAN_BITS     = 8;
    localparam int GAIN_INC      = 4;

    localparam int FRACTION [16] = '{
        32768, 31383, 30057, 28787, 27571, 26406, 25290, 24221,
        23198, 22218, 21279, 20380, 19519, 18694, 17904, 17147
    };
    localparam int TARGET_LEVEL [8] = '{23198, 16423, 11627, 8231, 5827, 4125, 2920, 2068};
    localparam int GATE_LEVEL [8]   = '{1036, 519, 260, 131, 65, 33, 16, 8};
    localparam int AMPLITUDES [7]   = '{0, 6, 60, 700, 1300, 5000, 32768};

    // Directed words, grouped by the register setting they run under:
    // reset setting, full +24 dB boost, mute code, deep attenuation.
    localparam int DIRECTED [25] = '{
        0, 1, -1, 32767, -32768, 12345, -12345,
        32767, -32768, 1000, -1000, 3, -3, 0, 5, -2048, 2047,
        100, -100, 32767, -32768,
        32767, -32767, 20000, -20000
    };

    typedef enum int {
        WAVE_NOISE,
        WAVE_SQUARE,
        WAVE_FULL_SCALE,
        WAVE_ONE_SIDED
    } t_wave;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          gain;
        logic                       gated;
    } t_agc_word;

    // ------------------------------------------------------------------
    // Clock, reset, channels and the device
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    agcng_in_if  pcm_in ();
    agcng_out_if pcm_out ();

    audio_agc_with_noise_gate_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (pcm_in),
        .o_out       (pcm_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] pcm_pending [$];   // words waiting for the driver
    t_agc_word                  agc_words_due [$]; // predicted words, oldest first

    int cycle_count = 0;
    int word_errors = 0;
    bit in_taken    = 1'b0;   // input word accepted at the last rising edge

    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int burst_left     = 1;
    int gap_left       = 0;
    int stall_slot     = 0;
    logic [31:0] stall_pattern = '0;

    // Register copies
    logic [2:0]  tgt_sel, gate_sel, atk_exp, dcy_exp;
    logic        gate_en;
    logic [7:0]  gain_floor, dflt_gain;
    logic [15:0] frame_len;

    // Running state of the gain loop and the noise detector
    logic [22:0]                abs_sum;
    logic [8:0]                 mean_left;
    logic                       quiet_flag;
    logic [14:0]                env_peak;
    logic [15:0]                frame_left;
    t_loop_mode                 loop_mode;
    logic [7:0]                 attack_left, decay_left;
    logic [7:0]                 gain_target;  // gain the loop has settled on
    logic [7:0]                 gain_live;    // gain in use, moves at sign changes
    logic signed [SAMPLE_W-1:0] prev_word;

    // ------------------------------------------------------------------
    // Gain loop prediction
    // ------------------------------------------------------------------
    task automatic restart_detector();
        abs_sum    = '0;
        mean_left  = 9'(1 << MEAN_BITS);
        quiet_flag = 1'b0;
        loop_mode  = LOOP_HOLD;
    endtask

    // One PCM word through noise detection, gain, then envelope and loop update.
    task automatic compute_agc_word(input logic signed [SAMPLE_W-1:0] x,
                                    output t_agc_word w);
        int ax, ay, y, thr, hi, g;
        bit do_step;
        // Noise detector on the input; full-scale negative clips to 32767
        ax = (x < 0) ? -int'(x) : int'(x);
        if (ax > 32767) ax = 32767;
        abs_sum   = abs_sum + 23'(ax);
        mean_left = mean_left - 9'd1;
        if (mean_left == 0) begin
            quiet_flag = ((abs_sum >> MEAN_BITS) < GATE_LEVEL[gate_sel]);
            abs_sum    = '0;
            mean_left  = 9'(1 << MEAN_BITS);
        end

        // Take a new gain only across a strict sign change
        if (gain_live != gain_target &&
            ((prev_word < 0 && x > 0) || (prev_word > 0 && x < 0))) begin
            gain_live = gain_target;
        end
        prev_word = x;

        w.gain  = gain_live;
        w.gated = gate_en & quiet_flag;
        if (gain_live == MUTE_CODE || w.gated) begin
            y = 0;
        end else begin
            y = (int'(x) * FRACTION[gain_live[3:0]]) >>> (11 + int'(gain_live[7:4]));
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
        end
        w.sample = 16'(y);

        // Envelope peak on the output, loop decision at the end of each frame
        ay = (y < 0) ? -y : y;
        if (ay > 32767) ay = 32767;
        if (env_peak < ay) env_peak = 15'(ay);
        if (frame_left > 1) begin
            frame_left = frame_left - 16'd1;
        end else begin
            hi  = int'(gain_floor[7:4]);
            thr = GATE_LEVEL[gate_sel];
            thr = (hi <= 4) ? (thr << (4 - hi)) : (thr >> (hi - 4));
            g   = int'(gain_target);
            if (env_peak > TARGET_LEVEL[tgt_sel]) begin
                do_step = 1'b1;
                if (loop_mode == LOOP_COMPRESS) begin
                    attack_left = attack_left - 8'd1;
                    do_step     = (attack_left == 0);
                end else begin
                    loop_mode = LOOP_COMPRESS;
                end
                if (do_step) begin
                    g = (g + GAIN_INC > 255) ? 255 : g + GAIN_INC;
                    attack_left = 8'(1 << atk_exp);
                end
            end else if (env_peak > thr) begin
                do_step = 1'b1;
                if (loop_mode == LOOP_EXPAND) begin
                    decay_left = decay_left - 8'd1;
                    do_step    = (decay_left == 0);
                end else begin
                    loop_mode = LOOP_EXPAND;
                end
                if (do_step) begin
                    g = (g > GAIN_INC) ? g - GAIN_INC : 0;
                    decay_left = 8'(1 << dcy_exp);
                end
            end
            if (g < int'(gain_floor)) g = int'(gain_floor);
            gain_target = 8'(g);
            env_peak    = '0;
            frame_left  = frame_len;
        end
    endtask

    // ------------------------------------------------------------------
    // Register writes: one cycle of write enable, mirrored in the copies
    // ------------------------------------------------------------------
    task automatic program_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_TARGET_SELECT: begin
                tgt_sel = data[2:0];
                restart_detector();
            end
            CFG_GATE_SELECT: begin
                gate_sel = data[2:0];
                restart_detector();
            end
            CFG_GATE_ENABLE: begin
                gate_en = data[0];
                restart_detector();
            end
            CFG_GAIN_FLOOR: gain_floor = data[7:0];
            CFG_DEFAULT_GAIN: begin
                dflt_gain   = data[7:0];
                gain_target = data[7:0];
                gain_live   = data[7:0];
            end
            CFG_FRAME_LENGTH: begin
                frame_len  = data;
                frame_left = data;
            end
            CFG_ATTACK_EXP: atk_exp = data[2:0];
            CFG_DECAY_EXP:  dcy_exp = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_directed(input int first, input int last);
        for (int k = first; k <= last; k++) pcm_pending.push_back(16'(DIRECTED[k]));
    endtask

    // A stretch of one waveform at one amplitude; rare full-scale spikes on top
    task automatic add_segment(input int count, input int amp);
        t_wave shape;
        int    half, v;
        shape = t_wave'($urandom_range(0, 3));
        half  = $urandom_range(1, 24);
        for (int k = 0; k < count; k++) begin
            case (shape)
                WAVE_NOISE:  v = int'($urandom_range(0, 2 * amp)) - amp;
                WAVE_SQUARE: begin
                    v = int'($urandom_range(amp / 2, amp));
                    if ((k / half) % 2) v = -v;
                end
                WAVE_FULL_SCALE: v = int'($urandom_range(0, 65535)) - 32768;
                default: v = int'($urandom_range(0, amp));
            endcase
            if ($urandom_range(0, 39) == 0) v = $urandom_range(0, 1) ? 32767 : -32768;
            if (v > 32767) v = 32767;
            pcm_pending.push_back(16'(v));
        end
    endtask

    // Hold until every word is sent and every predicted word has come back
    task automatic wait_until_drained();
        while (pcm_pending.size() != 0 || pcm_in.valid || agc_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps; a word is held until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!pcm_in.valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                pcm_in.valid <= 1'b0;
            end else if (pcm_pending.size() != 0) begin
                pcm_in.valid     <= 1'b1;
                pcm_in.sample_in <= pcm_pending.pop_front();
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    if (!src_gaps_on) gap_left = 0;
                    else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(5, 20);
                    else gap_left = $urandom_range(0, 3);
                end
            end else begin
                pcm_in.valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: a rotating stall pattern, reloaded whenever stall_slot wraps to zero
    always @(negedge i_clk) begin
        if (stall_slot == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '0;
                1: stall_pattern = $urandom & $urandom;
                2: stall_pattern = $urandom;
                default: stall_pattern = $urandom | $urandom;
            endcase
        end
        stall_slot = (stall_slot + 1) % 64;
        pcm_out.ready <= !(sink_stalls_on && stall_pattern[0]);
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    end

    // ------------------------------------------------------------------
    // Monitor: check the outgoing word first, then predict the incoming one,
    // so a word can never be matched against a prediction made at its own edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : word_tracker
        t_agc_word due;
        cycle_count = cycle_count + 1;
        in_taken    = i_rst_n && pcm_in.valid && pcm_in.ready;
        if (i_rst_n && pcm_out.valid && pcm_out.ready) begin
            if (agc_words_due.size() == 0) begin
                if (word_errors < 10)
                    $display("cycle %0d: word with none due: sample %0d gain %0d gated %0b",
                             cycle_count, pcm_out.sample_out, pcm_out.applied_gain,
                             pcm_out.gated);
                word_errors = word_errors + 1;
            end else begin
                due = agc_words_due.pop_front();
                if (pcm_out.sample_out !== due.sample || pcm_out.applied_gain !== due.gain ||
                    pcm_out.gated !== due.gated) begin
                    if (word_errors < 10)
                        $display({"cycle %0d: bad word: sample exp %0d got %0d, ",
                                  "gain exp %0d got %0d, gated exp %0b got %0b"},
                                 cycle_count, due.sample, pcm_out.sample_out,
                                 due.gain, pcm_out.applied_gain, due.gated, pcm_out.gated);
                    word_errors = word_errors + 1;
                end
            end
        end
        if (in_taken) begin
            compute_agc_word(pcm_in.sample_in, due);
            agc_words_due.push_back(due);
        end
    end

    // Hard stop in case the stream hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int remaining, len;
        // Drive every input from time zero, reset held low
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        pcm_in.valid     = 1'b0;
        pcm_in.sample_in = '0;
        pcm_out.ready    = 1'b0;

        // Register copies and loop state as after reset
        tgt_sel     = '0;
        gate_sel    = '0;
        gate_en     = 1'b0;
        gain_floor  = 8'd64;
        dflt_gain   = 8'd64;
        frame_len   = 16'd480;
        atk_exp     = '0;
        dcy_exp     = '0;
        restart_detector();
        env_peak    = '0;
        frame_left  = frame_len;
        attack_left = '0;
        decay_left  = '0;
        gain_target = dflt_gain;
        gain_live   = dflt_gain;
        prev_word   = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unity gain at reset, including both full-scale extremes
        push_directed(0, 6);
        wait_until_drained();

        // Directed: +24 dB with one-sample frames, so the loop decides on every word
        // and the boosted output saturates; new gains land only at sign changes
        program_reg(CFG_FRAME_LENGTH, 16'd0);
        program_reg(CFG_GAIN_FLOOR, 16'd0);
        program_reg(CFG_DEFAULT_GAIN, 16'd0);
        program_reg(CFG_ATTACK_EXP, 16'd0);
        program_reg(CFG_DECAY_EXP, 16'd0);
        push_directed(7, 16);
        wait_until_drained();

        // Directed: mute code, floor at the top of the range
        program_reg(CFG_DEFAULT_GAIN, 16'd255);
        program_reg(CFG_GAIN_FLOOR, 16'd255);
        push_directed(17, 20);
        wait_until_drained();

        // Directed: high floor, so the gate threshold shifts right and a
        // downward step is pulled back to the floor
        program_reg(CFG_GAIN_FLOOR, 16'h0090);
        program_reg(CFG_DEFAULT_GAIN, 16'h0090);
        push_directed(21, 24);
        wait_until_drained();

        // Random phases
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    // Gate on at the lowest level, gain free to drop to code 0
                    program_reg(CFG_TARGET_SELECT, 16'd0);
                    program_reg(CFG_GATE_SELECT, 16'd7);
                    program_reg(CFG_GATE_ENABLE, 16'd1);
                    program_reg(CFG_GAIN_FLOOR, 16'd0);
                    program_reg(CFG_DEFAULT_GAIN, 16'd2);
                    program_reg(CFG_FRAME_LENGTH, 16'd1);
                    program_reg(CFG_ATTACK_EXP, 16'd0);
                    program_reg(CFG_DECAY_EXP, 16'd0);
                end
                1: begin
                    // Longest frame and slowest steps; detector keeps running
                    program_reg(CFG_GAIN_FLOOR, 16'd255);
                    program_reg(CFG_DEFAULT_GAIN, 16'd200);
                    program_reg(CFG_FRAME_LENGTH, 16'hFFFF);
                    program_reg(CFG_ATTACK_EXP, 16'd7);
                    program_reg(CFG_DECAY_EXP, 16'd7);
                end
                2: begin
                    program_reg(CFG_TARGET_SELECT, 16'd7);
                    program_reg(CFG_GATE_SELECT, 16'd0);
                    program_reg(CFG_GATE_ENABLE, 16'd0);
                    program_reg(CFG_GAIN_FLOOR, 16'd64);
                    program_reg(CFG_DEFAULT_GAIN, 16'd64);
                    program_reg(CFG_FRAME_LENGTH, 16'd3);
                    program_reg(CFG_ATTACK_EXP, 16'd1);
                    program_reg(CFG_DECAY_EXP, 16'd7);
                end
                default: begin
                    // Random subset; junk in the unused upper data bits
                    for (int r = 0; r < 8; r++) begin
                        if ($urandom_range(0, 1)) begin
                            if (t_cfg_index'(r) == CFG_FRAME_LENGTH)
                                program_reg(CFG_FRAME_LENGTH, 16'($urandom_range(0, 12)));
                            else if (t_cfg_index'(r) == CFG_GAIN_FLOOR)
                                program_reg(CFG_GAIN_FLOOR, 16'(($urandom_range(0, 255) << 8)
                                                                | $urandom_range(0, 128)));
                            else
                                program_reg(t_cfg_index'(r), 16'($urandom));
                        end
                    end
                end
            endcase

            // One phase runs with no idling on either side
            src_gaps_on    = (phase != 3);
            sink_stalls_on = (phase != 3);

            // Open with a quiet block long enough for the detector to decide
            remaining = PHASE_WORDS;
            if (phase == 0) begin
                add_segment(260, 6);
                remaining = remaining - 260;
            end else if (phase == 2) begin
                add_segment(260, 700);
                remaining = remaining - 260;
            end
            while (remaining > 0) begin
                len = $urandom_range(0, 1) ? $urandom_range(4, 40) : $urandom_range(100, 300);
                if (len > remaining) len = remaining;
                add_segment(len, AMPLITUDES[$urandom_range(0, 6)]);
                remaining = remaining - len;
            end
            wait_until_drained();
        end

        if (word_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
